// ----- rtl/cfb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfb_pkg
// Shared types and constants for the control frame builder.
// ----------------------------------------------------------------------------
package cfb_pkg;

    // operation codes carried in the input tuser
    localparam logic OP_START   = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_MAGIC_FIRST  = 2'd0;
    localparam logic [1:0] CFG_MAGIC_SECOND = 2'd1;
    localparam logic [1:0] CFG_VERSION      = 2'd2;
    localparam logic [1:0] CFG_MAX_FRAME    = 2'd3;

    // frame geometry
    localparam logic [7:0] MAX_PAYLOAD    = 8'd32;
    localparam logic [8:0] FRAME_OVERHEAD = 9'd8;
    localparam logic [2:0] HDR_LAST_IDX   = 3'd6;
    localparam logic [2:0] HDR_XSUM_IDX   = 3'd7;
    localparam logic [7:0] MAX_FRAME_RST  = 8'd255;

    // command queue depth
    localparam int QUEUE_DEPTH = 4;

    // kind of work handed from front to back
    typedef enum logic [1:0] {
        CMD_REJECT  = 2'd0,
        CMD_HEADER  = 2'd1,
        CMD_PAYLOAD = 2'd2
    } t_kind;

    // one queued command
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data0;    // message type or payload byte
        logic [7:0] data1;    // sequence number
        logic [5:0] plen;     // payload length for the header
        logic [7:0] xsum;     // checksum to close the frame with
        logic       has_xsum; // command ends with the checksum byte
    } t_cmd;

    // configuration registers
    typedef struct packed {
        logic [7:0] magic_first;
        logic [7:0] magic_second;
        logic [7:0] version;
        logic [7:0] max_frame;
    } t_cfg;

endpackage

// ----- rtl/cfb_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfb_front
// Accepts input transactions, tracks the open frame and its running XOR,
// and turns every transaction into one command for the back end.
// ----------------------------------------------------------------------------
module cfb_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cfb_pkg::t_cfg i_cfg,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [31:0]   s_axis_tdata,   // [7:0] message_type, [15:8] frame_seq,
                                          // [21:16] payload_length, [29:22] payload_byte
    input  logic          s_axis_tuser,   // [0] operation
    input  logic          i_full,
    output logic          o_push,
    output cfb_pkg::t_cmd o_cmd
);
    import cfb_pkg::*;

    logic       r_open, n_open;
    logic [5:0] r_left, n_left;
    logic [7:0] r_xor,  n_xor;

    logic       accept;
    logic [7:0] mtype, seq, pbyte, hdr_xor, pay_xor;
    logic [5:0] plen;
    logic       too_long, too_big;

    assign s_axis_tready = !i_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_push        = accept;

    // field unpacking
    assign mtype = s_axis_tdata[7:0];
    assign seq   = s_axis_tdata[15:8];
    assign plen  = s_axis_tdata[21:16];
    assign pbyte = s_axis_tdata[29:22];

    // start checks and header checksum
    assign too_long = {2'b00, plen} > MAX_PAYLOAD;
    assign too_big  = ({3'b000, plen} + FRAME_OVERHEAD) > {1'b0, i_cfg.max_frame};
    assign hdr_xor  = i_cfg.magic_first ^ i_cfg.magic_second ^ i_cfg.version
                    ^ mtype ^ seq ^ {2'b00, plen};
    assign pay_xor  = r_xor ^ pbyte;

    // classify and build the command
    always_comb begin
        n_open = r_open;
        n_left = r_left;
        n_xor  = r_xor;
        o_cmd  = '{kind: CMD_REJECT, data0: 8'h00, data1: 8'h00, plen: 6'd0,
                   xsum: 8'h00, has_xsum: 1'b0};
        if (s_axis_tuser == OP_START) begin
            n_open = 1'b0;
            n_left = 6'd0;
            n_xor  = 8'h00;
            if (!(too_long || too_big)) begin
                o_cmd.kind     = CMD_HEADER;
                o_cmd.data0    = mtype;
                o_cmd.data1    = seq;
                o_cmd.plen     = plen;
                o_cmd.xsum     = hdr_xor;
                o_cmd.has_xsum = (plen == 6'd0);
                if (plen != 6'd0) begin
                    n_open = 1'b1;
                    n_left = plen;
                    n_xor  = hdr_xor;
                end
            end
        end else if (r_open) begin
            o_cmd.kind  = CMD_PAYLOAD;
            o_cmd.data0 = pbyte;
            o_cmd.xsum  = pay_xor;
            n_left      = r_left - 6'd1;
            n_xor       = pay_xor;
            if (r_left == 6'd1) begin
                o_cmd.has_xsum = 1'b1;
                n_open         = 1'b0;
                n_xor          = 8'h00;
            end
        end
    end

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_left <= 6'd0;
            r_xor  <= 8'h00;
        end else if (accept) begin
            r_open <= n_open;
            r_left <= n_left;
            r_xor  <= n_xor;
        end
    end

endmodule

// ----- rtl/cfb_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfb_queue
// Small register queue of commands between front and back end.
// ----------------------------------------------------------------------------
module cfb_queue #(
    parameter int DEPTH = cfb_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cfb_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_empty,
    output logic          o_full,
    output cfb_pkg::t_cmd o_cmd
);
    import cfb_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == FULL_CNT);
    assign o_cmd   = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ----- rtl/cfb_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfb_back
// Expands the command at the queue head into frame bytes, one per cycle
// unless the output stalls, into a registered output stage.
// ----------------------------------------------------------------------------
module cfb_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cfb_pkg::t_cfg i_cfg,
    input  logic          i_empty,
    input  cfb_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [7:0]    m_axis_tdata,   // [7:0] out_byte
    output logic          m_axis_tlast,   // frame_end
    output logic          m_axis_tuser    // [0] rejected
);
    import cfb_pkg::*;

    logic [2:0] r_idx, n_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_end, r_rej;

    logic       advance;
    logic [7:0] cur_byte;
    logic       cur_end, cur_rej, cur_last;

    // byte selection for the current position of the head command
    always_comb begin
        cur_byte = 8'h00;
        cur_end  = 1'b0;
        cur_rej  = 1'b0;
        cur_last = 1'b1;
        case (i_cmd.kind)
            CMD_REJECT: begin
                cur_end = 1'b1;
                cur_rej = 1'b1;
            end
            CMD_HEADER: begin
                case (r_idx)
                    3'd0:    cur_byte = i_cfg.magic_first;
                    3'd1:    cur_byte = i_cfg.magic_second;
                    3'd2:    cur_byte = i_cfg.version;
                    3'd3:    cur_byte = i_cmd.data0;
                    3'd4:    cur_byte = i_cmd.data1;
                    3'd5:    cur_byte = {2'b00, i_cmd.plen};
                    3'd6:    cur_byte = 8'h00;
                    default: begin
                        cur_byte = i_cmd.xsum;
                        cur_end  = 1'b1;
                    end
                endcase
                cur_last = (r_idx == HDR_XSUM_IDX)
                        || (r_idx == HDR_LAST_IDX && !i_cmd.has_xsum);
            end
            CMD_PAYLOAD: begin
                if (r_idx == 3'd0) begin
                    cur_byte = i_cmd.data0;
                    cur_last = !i_cmd.has_xsum;
                end else begin
                    cur_byte = i_cmd.xsum;
                    cur_end  = 1'b1;
                end
            end
            default: begin
                cur_end = 1'b1;
                cur_rej = 1'b1;
            end
        endcase
    end

    // step when there is work and the output stage is free
    assign advance = !i_empty && (!r_valid || m_axis_tready);
    assign o_pop   = advance && cur_last;
    assign n_idx   = advance ? (cur_last ? 3'd0 : r_idx + 3'd1) : r_idx;

    // position counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 3'd0;
            r_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (advance) begin
                r_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_byte <= cur_byte;
            r_end  <= cur_end;
            r_rej  <= cur_rej;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_byte;
    assign m_axis_tlast  = r_end;
    assign m_axis_tuser  = r_rej;

`ifndef SYNTHESIS
    // a rejection is a single closing zero byte
    a_reject_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_rej |-> r_end && (r_byte == 8'h00))
        else $error("rejected transaction not a closing zero byte");

    // the position only moves while a command is at the head
    a_idx_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != 3'd0) |-> !i_empty)
        else $error("byte position set with empty queue");

    // payload and reject commands span at most two and one bytes
    a_idx_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty && (i_cmd.kind == CMD_PAYLOAD) |-> (r_idx <= 3'd1))
        else $error("payload command position out of range");

    a_idx_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty && (i_cmd.kind == CMD_REJECT) |-> (r_idx == 3'd0))
        else $error("reject command position out of range");
`endif

endmodule

// ----- rtl/control_frame_builder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// control_frame_builder
// Control frame builder: byte framer with a closing XOR checksum byte.
// ----------------------------------------------------------------------------
// A start transaction (tuser 0) produces a seven-byte header (two magic bytes,
// version, type, sequence, length, zero) and, for an empty payload, the
// checksum byte right after it; each payload transaction (tuser 1) produces
// its byte and, on the last one, the checksum. A bad start or a stray payload
// byte produces one zero byte with tlast and tuser set. The input side takes
// one transaction per cycle while the command queue (QUEUE_DEPTH entries) has
// room; unless stalled, the output side emits one byte per cycle, 7 or 8 for
// a start that passes its checks, 1 or 2 for a payload byte. Payload streams
// run at one byte per cycle unless stalled; the queue lets the input run ahead
// of header bytes by up to QUEUE_DEPTH commands. The user writes configuration
// through i_cfg_we / i_cfg_addr / i_cfg_data only while no frame is in flight.
// ----------------------------------------------------------------------------
module control_frame_builder #(
    parameter int QUEUE_DEPTH = cfb_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [7:0]  i_cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [7:0] message_type, [15:8] frame_seq,
                                        // [21:16] payload_length, [29:22] payload_byte
    input  logic        s_axis_tuser,   // [0] operation
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast,   // frame_end
    output logic        m_axis_tuser    // [0] rejected
);
    import cfb_pkg::*;

    t_cfg r_cfg;
    t_cmd push_cmd, head_cmd;
    logic push, pop, q_empty, q_full;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{magic_first: 8'h00, magic_second: 8'h00, version: 8'h00,
                       max_frame: MAX_FRAME_RST};
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_MAGIC_FIRST:  r_cfg.magic_first  <= i_cfg_data;
                CFG_MAGIC_SECOND: r_cfg.magic_second <= i_cfg_data;
                CFG_VERSION:      r_cfg.version      <= i_cfg_data;
                CFG_MAX_FRAME:    r_cfg.max_frame    <= i_cfg_data;
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    // classify incoming transactions
    cfb_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_full        (q_full),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    // command queue
    cfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_full  (q_full),
        .o_cmd   (head_cmd)
    );

    // byte generation
    cfb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_empty       (q_empty),
        .i_cmd         (head_cmd),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ----- dv/control_frame_builder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// control_frame_builder_tb
// Self-checking bench for the control frame builder. A behavioral predictor
// tracks the open frame, the bytes still due and the running XOR. It queues
// every header, payload, checksum and reject byte the block should emit, and
// the output monitor compares each output transaction with the oldest queued
// byte. Directed tests cover field extremes and each error path. Random
// phases mix well-formed frames with truncated frames, stray payload bytes
// and oversize requests, under changing register settings and random idling
// on both stream sides.
// ----------------------------------------------------------------------------
module control_frame_builder_tb;
    import cfb_pkg::*;

    // one byte leaving the block
    typedef struct packed {
        logic [7:0] data;
        logic       frame_end;
        logic       rejected;
    } t_frame_byte;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [1:0]  i_cfg_addr    = CFG_MAGIC_FIRST;
    logic [7:0]  i_cfg_data    = 8'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = 32'd0;
    logic        s_axis_tuser  = OP_START;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;

    // predictor copy of registers and frame state
    logic [7:0]  cfg_magic_first  = 8'd0;
    logic [7:0]  cfg_magic_second = 8'd0;
    logic [7:0]  cfg_version      = 8'd0;
    logic [7:0]  cfg_max_frame    = MAX_FRAME_RST;
    logic        frm_open = 1'b0;
    logic [5:0]  frm_left = 6'd0;
    logic [7:0]  frm_xor  = 8'd0;

    t_frame_byte expected_bytes[$];
    t_frame_byte exp_byte;
    int          errors       = 0;
    int          items_sent   = 0;
    int          tx_idle_pct  = 0;
    int          rx_stall_pct = 0;

    control_frame_builder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 10 ns clock
    always #5 i_clk = ~i_clk;

    // run limit
    initial begin
        #5_000_000;
        $display("control_frame_builder verification failed");
        $finish;
    end

    // receiver backpressure and output check
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected output byte %02h last %b rejected %b",
                         $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
                errors++;
            end else begin
                exp_byte = expected_bytes.pop_front();
                if (m_axis_tdata !== exp_byte.data) begin
                    $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                             $time, exp_byte.data, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tlast !== exp_byte.frame_end) begin
                    $display("%0t: frame_end mismatch: expected %b, actual %b",
                             $time, exp_byte.frame_end, m_axis_tlast);
                    errors++;
                end
                if (m_axis_tuser !== exp_byte.rejected) begin
                    $display("%0t: rejected mismatch: expected %b, actual %b",
                             $time, exp_byte.rejected, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    // queue the bytes one input transaction produces
    task automatic predict_frame_bytes(input logic op, input logic [7:0] mtype,
                                       input logic [7:0] seq, input logic [5:0] plen,
                                       input logic [7:0] pbyte);
        logic [7:0] hdr [7];
        logic [7:0] x;
        x = 8'd0;
        if (op == OP_START) begin
            frm_open = 1'b0;
            frm_left = 6'd0;
            frm_xor  = 8'd0;
            if (int'(plen) > int'(MAX_PAYLOAD) ||
                int'(plen) + int'(FRAME_OVERHEAD) > int'(cfg_max_frame)) begin
                expected_bytes.push_back('{8'd0, 1'b1, 1'b1});
            end else begin
                hdr[0] = cfg_magic_first;
                hdr[1] = cfg_magic_second;
                hdr[2] = cfg_version;
                hdr[3] = mtype;
                hdr[4] = seq;
                hdr[5] = {2'b00, plen};
                hdr[6] = 8'd0;
                for (int i = 0; i < 7; i++) begin
                    expected_bytes.push_back('{hdr[i], 1'b0, 1'b0});
                    x ^= hdr[i];
                end
                if (plen == 6'd0) begin
                    expected_bytes.push_back('{x, 1'b1, 1'b0});
                end else begin
                    frm_open = 1'b1;
                    frm_left = plen;
                    frm_xor  = x;
                end
            end
        end else if (!frm_open) begin
            // stray payload byte, state untouched
            expected_bytes.push_back('{8'd0, 1'b1, 1'b1});
        end else begin
            expected_bytes.push_back('{pbyte, 1'b0, 1'b0});
            frm_xor ^= pbyte;
            frm_left -= 6'd1;
            if (frm_left == 6'd0) begin
                expected_bytes.push_back('{frm_xor, 1'b1, 1'b0});
                frm_open = 1'b0;
                frm_xor  = 8'd0;
            end
        end
    endtask

    // present one input transaction and hold it until accepted
    task automatic send_item(input logic op, input logic [7:0] mtype, input logic [7:0] seq,
                             input logic [5:0] plen, input logic [7:0] pbyte);
        bit idled;
        idled = 1'b0;
        while ($urandom_range(99) < tx_idle_pct) begin
            if (!idled) s_axis_tvalid <= 1'b0;
            idled = 1'b1;
            @(posedge i_clk);
        end
        predict_frame_bytes(op, mtype, seq, plen, pbyte);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {2'b00, pbyte, plen, seq, mtype};
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic send_start(input logic [7:0] mtype, input logic [7:0] seq,
                              input logic [5:0] plen);
        send_item(OP_START, mtype, seq, plen, 8'($urandom));
    endtask

    task automatic send_payload(input logic [7:0] pbyte);
        send_item(OP_PAYLOAD, 8'($urandom), 8'($urandom), 6'($urandom), pbyte);
    endtask

    // start a frame of length plen and supply count random payload bytes
    task automatic send_frame(input logic [5:0] plen, input int count);
        send_start(8'($urandom), 8'($urandom), plen);
        repeat (count) send_payload(8'($urandom));
    endtask

    // stop sending until every queued byte has come out, then settle
    task automatic wait_drained(input int settle);
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_bytes.size() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [7:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_MAGIC_FIRST:  cfg_magic_first  = value;
            CFG_MAGIC_SECOND: cfg_magic_second = value;
            CFG_VERSION:      cfg_version      = value;
            CFG_MAX_FRAME:    cfg_max_frame    = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // reprogram every register once the block is idle
    task automatic set_config(input logic [7:0] mf, input logic [7:0] ms,
                              input logic [7:0] ver, input logic [7:0] maxf);
        wait_drained(16);
        write_register(CFG_MAGIC_FIRST, mf);
        write_register(CFG_MAGIC_SECOND, ms);
        write_register(CFG_VERSION, ver);
        write_register(CFG_MAX_FRAME, maxf);
    endtask

    // field extremes, empty and short frames, stray payload, overlong length, cut frame
    task automatic test_directed;
        set_config(8'hA5, 8'h5A, 8'h01, MAX_FRAME_RST);
        send_start(8'hFF, 8'h00, 6'd0);
        send_start(8'h00, 8'hFF, 6'd0);
        send_start(8'h3C, 8'hC3, 6'd1);
        send_payload(8'hFF);
        send_start(8'h81, 8'h7E, 6'd2);
        send_payload(8'h00);
        send_payload(8'h80);
        // payload byte with no open frame
        send_payload(8'h55);
        // length above the maximum payload
        send_start(8'h12, 8'h34, 6'd33);
        send_start(8'hFF, 8'hFF, 6'd63);
        // new start drops the unfinished frame
        send_start(8'h01, 8'h02, 6'd3);
        send_payload(8'hAA);
        send_start(8'h03, 8'h04, 6'd1);
        send_payload(8'h01);
        send_payload(8'h7F);
    endtask

    // frame size limit at its extremes
    task automatic test_frame_limits;
        set_config(8'h00, 8'h00, 8'h00, 8'd8);
        send_start(8'h10, 8'h20, 6'd0);
        send_start(8'h11, 8'h21, 6'd1);
        send_payload(8'h33);
        set_config(8'hFF, 8'hFF, 8'hFF, 8'd40);
        send_frame(6'd32, 32);
        send_start(8'h22, 8'h44, 6'd33);
        set_config(8'h12, 8'h34, 8'h56, 8'd39);
        send_start(8'h66, 8'h77, 6'd32);
        send_frame(6'd31, 31);
        set_config(8'h00, 8'hFF, 8'h80, MAX_FRAME_RST);
        send_frame(6'd32, 32);
    endtask

    // random traffic under one idling mix and one register setting
    task automatic test_random_phase(input int tx_pct, input int rx_pct, input int n_items);
        int target;
        int sel;
        int room;
        int plen;
        target = items_sent + n_items;
        case ($urandom_range(3))
            0: room = 8;
            1: room = 255;
            2: room = $urandom_range(8, 255);
            default: room = 8 + $urandom_range(0, 40);
        endcase
        set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'(room));
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        room = cfg_max_frame - 8;
        if (room > 32) room = 32;
        while (items_sent < target) begin
            sel = $urandom_range(99);
            if (sel < 70) begin
                // well-formed frame, mostly short
                if ($urandom_range(9) == 0) plen = $urandom_range(0, room);
                else plen = $urandom_range(0, (room < 6) ? room : 6);
                send_frame(6'(plen), plen);
            end else if (sel < 80) begin
                // frame cut short by the next start
                plen = $urandom_range(1, room > 1 ? room : 1);
                send_frame(6'(plen), $urandom_range(0, plen - 1));
            end else if (sel < 88) begin
                send_payload(8'($urandom));
            end else if (sel < 95) begin
                send_start(8'($urandom), 8'($urandom), 6'($urandom_range(33, 63)));
            end else if (room < 32) begin
                // length fits but whole frame exceeds the limit
                send_start(8'($urandom), 8'($urandom), 6'($urandom_range(room + 1, 32)));
            end else begin
                send_payload(8'($urandom));
            end
            if ($urandom_range(24) == 0) wait_drained(0);
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_frame_limits();
        test_random_phase(0, 0, 78);
        test_random_phase(50, 0, 78);
        test_random_phase(0, 50, 78);
        test_random_phase(30, 30, 78);
        wait_drained(20);
        if (errors == 0) begin
            $display("control_frame_builder verification clean");
        end else begin
            $display("control_frame_builder verification failed");
        end
        $finish;
    end

endmodule
